@@ hw/rtl/alc_pkg.sv @@
`default_nettype none

package alc_pkg;

   // Number of ranked entries kept during a window.
   localparam int RANK_DEPTH = 5;

   localparam int SAMPLE_W = 8;
   localparam int COUNT_W  = 16;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Reset values of the configuration registers.
   localparam logic [15:0] WINDOW_LENGTH_RST  = 16'd1000;
   localparam logic [15:0] DOMINANT_COUNT_RST = 16'd200;
   localparam logic [7:0]  LOW_LIMIT_RST      = 8'h05;
   localparam logic [7:0]  HIGH_LIMIT_RST     = 8'h3f;

   // Reported level classes.
   typedef enum logic [1:0] {
      EV_IDLE = 2'd0,
      EV_LOW  = 2'd1,
      EV_MID  = 2'd2,
      EV_HIGH = 2'd3
   } event_type;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      REG_WINDOW_LENGTH  = 2'd0,
      REG_DOMINANT_COUNT = 2'd1,
      REG_LOW_LIMIT      = 2'd2,
      REG_HIGH_LIMIT     = 2'd3
   } reg_idx_type;

   // Configuration values handed from the register file to the core.
   typedef struct packed {
      logic [15:0] window_length;
      logic [15:0] dominant_count;
      logic [7:0]  low_limit;
      logic [7:0]  high_limit;
   } cfg_type;

   // Signals one cell hands to the next one down the chain.
   typedef struct packed {
      logic                le;     // stored value is at or below the sample
      logic                shift;  // an insert above pushes entries down
      logic [SAMPLE_W-1:0] value;  // stored value of this cell
      logic [COUNT_W-1:0]  count;  // stored hit count of this cell
      logic                found;  // a dominant entry was found at or above
      logic [SAMPLE_W-1:0] pick;   // value of that dominant entry
   } link_type;

endpackage

`default_nettype wire

@@ hw/rtl/alc_csr.sv @@
`default_nettype none

module alc_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [alc_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [alc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [alc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                            csr_pready,
   output alc_pkg::cfg_type                cfg
);
   import alc_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_WINDOW_LENGTH:  cfg_in.window_length  = csr_pwdata[15:0];
            REG_DOMINANT_COUNT: cfg_in.dominant_count = csr_pwdata[15:0];
            REG_LOW_LIMIT:      cfg_in.low_limit      = csr_pwdata[7:0];
            REG_HIGH_LIMIT:     cfg_in.high_limit     = csr_pwdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length  <= WINDOW_LENGTH_RST;
         cfg_ff.dominant_count <= DOMINANT_COUNT_RST;
         cfg_ff.low_limit      <= LOW_LIMIT_RST;
         cfg_ff.high_limit     <= HIGH_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back multiplexer.
   always_comb begin
      unique case (idx)
         REG_WINDOW_LENGTH:  csr_prdata = {16'd0, cfg_ff.window_length};
         REG_DOMINANT_COUNT: csr_prdata = {16'd0, cfg_ff.dominant_count};
         REG_LOW_LIMIT:      csr_prdata = {24'd0, cfg_ff.low_limit};
         REG_HIGH_LIMIT:     csr_prdata = {24'd0, cfg_ff.high_limit};
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/alc_cell.sv @@
`default_nettype none

module alc_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         clear,
   input  wire logic                         collect,
   input  wire logic [alc_pkg::SAMPLE_W-1:0] sample,
   input  wire logic [alc_pkg::COUNT_W-1:0]  dominant_count,
   input  alc_pkg::link_type                 prev,
   output alc_pkg::link_type                 next
);
   import alc_pkg::*;

   logic [SAMPLE_W-1:0] value_ff, value_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                le;
   logic                is_pos;

   // This cell is the insert position when it is the first one at or below the sample.
   assign le     = (value_ff <= sample);
   assign is_pos = le & ~prev.le;

   always_comb begin
      value_in = value_ff;
      count_in = count_ff;
      if (clear) begin
         value_in = '0;
         count_in = '0;
      end else if (collect) begin
         if (prev.shift) begin
            // An insert above pushes the neighbor's entry into this cell.
            value_in = prev.value;
            count_in = prev.count;
         end else if (is_pos) begin
            if (value_ff == sample) begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end else begin
               value_in = sample;
               count_in = {{(COUNT_W-1){1'b0}}, 1'b1};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         count_ff <= '0;
      end else begin
         value_ff <= value_in;
         count_ff <= count_in;
      end
   end

   // Hand insert and dominant search information to the next cell.
   always_comb begin
      next.le    = le;
      next.shift = prev.shift | (is_pos & (value_ff != sample));
      next.value = value_ff;
      next.count = count_ff;
      next.found = prev.found | (count_ff >= dominant_count);
      next.pick  = prev.found ? prev.pick : value_ff;
   end

endmodule

`default_nettype wire

@@ hw/rtl/adc_level_mode_classifier_core.sv @@
// Channel  | Direction | Ports      | Contents
// ---------+-----------+------------+------------------------------------------
// req      | in        | req_t*     | tdata: sample[7:0]; tuser: active
// rsp      | out       | rsp_t*     | tdata: event_res[1:0], changed[2], 0[7:3]
// csr      | in/out    | csr_p*     | four registers at byte addresses 0,4,8,12
//
// The result is registered and shows on rsp in the cycle after the item is
// taken. The rank store is a chain of cells that updates in the accepting
// cycle, so one item per cycle is sustained while rsp_tready stays high.
// A new item is taken while the result register is empty or being emptied.
// Reset is synchronous and clears the store, window counter and held event.
`default_nettype none

module adc_level_mode_classifier_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,   // sample[7:0]
   input  wire logic                       req_tuser,   // active
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [7:0]                 rsp_tdata,   // event_res[1:0], changed[2]
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [alc_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [alc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [alc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                            csr_pready
);
   import alc_pkg::*;

   cfg_type             cfg;
   link_type            link [RANK_DEPTH+1];
   logic                accept;
   logic                active;
   logic                in_window;
   logic                clear;
   logic                collect;
   logic [SAMPLE_W-1:0] chosen;
   event_type           class_ev;

   logic [15:0] win_cnt_ff, win_cnt_in;
   event_type   event_ff, event_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        changed_ff, changed_in;

   alc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake and step decode.
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign active     = req_tuser;
   assign in_window  = (win_cnt_ff < cfg.window_length);
   assign collect    = accept & active & in_window;
   assign clear      = accept & ~(active & in_window);

   // Head of the chain: nothing above the first cell.
   assign link[0] = '0;

   for (genvar k = 0; k < RANK_DEPTH; k++) begin : g_cell
      alc_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .clear          (clear),
         .collect        (collect),
         .sample         (req_tdata),
         .dominant_count (cfg.dominant_count),
         .prev           (link[k]),
         .next           (link[k+1])
      );
   end

   // Only the top entries but the last take part in the dominant search.
   assign chosen = link[RANK_DEPTH-1].found ? link[RANK_DEPTH-1].pick : link[1].value;

   always_comb begin
      if (chosen < cfg.low_limit) begin
         class_ev = EV_LOW;
      end else if (chosen < cfg.high_limit) begin
         class_ev = EV_MID;
      end else begin
         class_ev = EV_HIGH;
      end
   end

   // Window counter and held event.
   always_comb begin
      win_cnt_in = win_cnt_ff;
      event_in   = event_ff;
      if (accept) begin
         if (!active) begin
            win_cnt_in = '0;
            event_in   = EV_IDLE;
         end else if (in_window) begin
            win_cnt_in = win_cnt_ff + 1'b1;
         end else begin
            win_cnt_in = '0;
            event_in   = class_ev;
         end
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      changed_in   = changed_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         changed_in   = (event_in != event_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_cnt_ff   <= '0;
         event_ff     <= EV_IDLE;
         rsp_valid_ff <= 1'b0;
         changed_ff   <= 1'b0;
      end else begin
         win_cnt_ff   <= win_cnt_in;
         event_ff     <= event_in;
         rsp_valid_ff <= rsp_valid_in;
         changed_ff   <= changed_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, changed_ff, event_ff};

   // An accepted item always leaves a result in the output register.
   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item left no result");

   // An inactive item clears the window and reports idle.
   a_inactive_clears : assert property (@(posedge clock) disable iff (reset)
      (accept && !active) |=> (win_cnt_ff == '0 && event_ff == EV_IDLE))
      else $error("inactive item did not clear state");

   // The rank store stays in non-increasing order.
   for (genvar k = 1; k < RANK_DEPTH; k++) begin : g_order_chk
      a_sorted : assert property (@(posedge clock) disable iff (reset)
         link[k].value >= link[k+1].value)
         else $error("rank store out of order");
   end

endmodule

`default_nettype wire
